/* hw/rtl/keyed_fixed_window_rate_limiter_top_defines.svh */
// ----------------------------------------------------------------------------
// Keyed fixed-window rate limiter: assertion macros
// Shared property wrappers used by the assertion section of the top level.
// ----------------------------------------------------------------------------
`ifndef KEYED_FIXED_WINDOW_RATE_LIMITER_TOP_DEFINES_SVH
`define KEYED_FIXED_WINDOW_RATE_LIMITER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KFWRL_ASSERT_NOW(label, rstn, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KFWRL_ASSERT_NEXT(label, rstn, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/kfwrl_pkg.sv */
// ----------------------------------------------------------------------------
// kfwrl_pkg
// Types, sizes and codes shared by the keyed fixed-window rate limiter.
// ----------------------------------------------------------------------------
package kfwrl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 64;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W  = 17;
    localparam int LIM_W  = 16;
    localparam int TIME_W = 40;

    // Operation codes of an input word.
    localparam logic [1:0] OP_REQUEST  = 2'd0;
    localparam logic [1:0] OP_ADD_USER = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOTREADY   = 3'd1;
    localparam logic [2:0] ST_RATELIMIT  = 3'd2;
    localparam logic [2:0] ST_PROCESSED  = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_READY       = 2'd0;
    localparam logic [1:0] CFG_ADMIN_KEY_A = 2'd1;
    localparam logic [1:0] CFG_ADMIN_KEY_B = 2'd2;
    localparam logic [1:0] CFG_ADMIN_COUNT = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [63:0]       client_key;
        logic [TIME_W-1:0] now_seconds;
        logic [TIME_W-1:0] expiry_time;
        logic [LIM_W-1:0]  rate_limit;
    } in_word_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] use_count;
    } out_word_t;

    // One row of the client table.
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TIME_W-1:0]   expiry;
        logic [LIM_W-1:0]    limit;
        logic [CNT_W-1:0]    count;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // Table RAM access from the sequencer.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        row_t             wr_data;
    } ram_req_t;

    // Configuration state seen by the sequencer.
    typedef struct packed {
        logic ready;
        logic admin_hit;
    } cfg_stat_t;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic              busy;
        logic [FILL_W-1:0] fill;
    } seq_stat_t;

endpackage

/* hw/rtl/kfwrl_ram.sv */
// ----------------------------------------------------------------------------
// kfwrl_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module kfwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           aclk,
    input  logic                                           wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]                               wr_data,
    input  logic                                           rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
    output logic [WIDTH-1:0]                               rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/kfwrl_cfg.sv */
// ----------------------------------------------------------------------------
// kfwrl_cfg
// Configuration registers and the administrator key match.
// ----------------------------------------------------------------------------
module kfwrl_cfg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_wdata,
    input  logic [63:0]           probe_key,
    output kfwrl_pkg::cfg_stat_t  cfg_stat
);

    logic        ready_reg;
    logic [63:0] admin_a_reg;
    logic [63:0] admin_b_reg;
    logic [1:0]  admin_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg       <= 1'b0;
            admin_a_reg     <= '0;
            admin_b_reg     <= '0;
            admin_count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                kfwrl_pkg::CFG_READY:       ready_reg       <= cfg_wdata[0];
                kfwrl_pkg::CFG_ADMIN_KEY_A: admin_a_reg     <= cfg_wdata;
                kfwrl_pkg::CFG_ADMIN_KEY_B: admin_b_reg     <= cfg_wdata;
                kfwrl_pkg::CFG_ADMIN_COUNT: admin_count_reg <= cfg_wdata[1:0];
            endcase
        end
    end

    // A count of three behaves as two: bit 1 enables the second key.
    always_comb begin
        cfg_stat.ready     = ready_reg;
        cfg_stat.admin_hit =
            ((admin_count_reg != 2'd0) &&
             (probe_key[kfwrl_pkg::KEY_BITS-1:0] == admin_a_reg[kfwrl_pkg::KEY_BITS-1:0])) ||
            (admin_count_reg[1] &&
             (probe_key[kfwrl_pkg::KEY_BITS-1:0] == admin_b_reg[kfwrl_pkg::KEY_BITS-1:0]));
    end

endmodule

/* hw/rtl/kfwrl_seq.sv */
// ----------------------------------------------------------------------------
// kfwrl_seq
// Sequencer: scans the client table through one key comparator, updates
// the matching row and holds the result word in an output register.
// ----------------------------------------------------------------------------
module kfwrl_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kfwrl_pkg::cfg_stat_t  cfg_stat,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  kfwrl_pkg::in_word_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output kfwrl_pkg::out_word_t  m_data,
    output kfwrl_pkg::ram_req_t   ram_req,
    input  kfwrl_pkg::row_t       ram_rd,
    output kfwrl_pkg::seq_stat_t  seq_stat
);

    localparam int IDX_W  = kfwrl_pkg::IDX_W;
    localparam int FILL_W = kfwrl_pkg::FILL_W;
    localparam int CNT_W  = kfwrl_pkg::CNT_W;
    localparam int LIM_W  = kfwrl_pkg::LIM_W;
    localparam int TIME_W = kfwrl_pkg::TIME_W;
    localparam int DEPTH  = kfwrl_pkg::TABLE_DEPTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE,
        S_DONE
    } state_t;

    state_t                         state_reg,      state_next;
    logic [1:0]                     op_reg,         op_next;
    logic [kfwrl_pkg::KEY_BITS-1:0] key_reg,        key_next;
    logic [TIME_W-1:0]              now_reg,        now_next;
    logic [TIME_W-1:0]              expiry_reg,     expiry_next;
    logic [LIM_W-1:0]               limit_reg,      limit_next;
    logic [FILL_W-1:0]              scan_reg,       scan_next;
    logic                           pend_reg,       pend_next;
    logic [IDX_W-1:0]               pend_idx_reg,   pend_idx_next;
    logic [IDX_W-1:0]               hit_idx_reg,    hit_idx_next;
    logic [FILL_W-1:0]              fill_reg,       fill_next;
    logic [DEPTH-1:0]               cvalid_reg,     cvalid_next;
    logic [2:0]                     res_status_reg, res_status_next;
    logic [CNT_W-1:0]               res_count_reg,  res_count_next;
    logic                           m_valid_reg,    m_valid_next;
    kfwrl_pkg::out_word_t           m_data_reg,     m_data_next;

    logic             key_match;
    logic             scan_more;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W:0]   cnt_inc;
    logic [CNT_W-1:0] cnt_cap;
    logic [CNT_W-1:0] cnt_new;
    logic             over;

    // Shared compare unit: one table key per cycle against the held key.
    assign key_match = pend_reg && (ram_rd.key == key_reg);
    assign scan_more = (scan_reg < fill_reg);

    // A count whose window was cleared by a tick reads as zero.
    assign cnt_eff = cvalid_reg[hit_idx_reg] ? ram_rd.count : '0;
    assign cnt_inc = {1'b0, cnt_eff} + (CNT_W + 1)'(1);
    assign cnt_cap = {1'b0, ram_rd.limit} + CNT_W'(1);
    assign cnt_new = (cnt_inc > {1'b0, cnt_cap}) ? cnt_cap : cnt_inc[CNT_W-1:0];
    assign over    = (cnt_new > {1'b0, ram_rd.limit}) || (now_reg > ram_rd.expiry);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        expiry_next     = expiry_reg;
        limit_next      = limit_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        hit_idx_next    = hit_idx_reg;
        fill_next       = fill_reg;
        cvalid_next     = cvalid_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        ram_req         = '0;
        ram_req.rd_addr = scan_reg[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next        = s_data.operation;
                    key_next       = s_data.client_key[kfwrl_pkg::KEY_BITS-1:0];
                    now_next       = s_data.now_seconds;
                    expiry_next    = s_data.expiry_time;
                    limit_next     = s_data.rate_limit;
                    res_count_next = '0;
                    priority if (s_data.operation == kfwrl_pkg::OP_TICK) begin
                        cvalid_next     = '0;
                        res_status_next = kfwrl_pkg::ST_OK;
                        state_next      = S_DONE;
                    end else if (s_data.operation == kfwrl_pkg::OP_UNUSED ||
                                 !cfg_stat.ready) begin
                        res_status_next = kfwrl_pkg::ST_NOTREADY;
                        state_next      = S_DONE;
                    end else if (s_data.operation == kfwrl_pkg::OP_REQUEST &&
                                 cfg_stat.admin_hit) begin
                        res_status_next = kfwrl_pkg::ST_OK;
                        state_next      = S_DONE;
                    end else begin
                        scan_next  = '0;
                        pend_next  = 1'b0;
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH: begin
                priority if (key_match) begin
                    hit_idx_next = pend_idx_reg;
                    pend_next    = 1'b0;
                    state_next   = S_UPDATE;
                end else if (scan_more) begin
                    ram_req.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + FILL_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    priority if (op_reg == kfwrl_pkg::OP_REQUEST) begin
                        res_status_next = kfwrl_pkg::ST_RATELIMIT;
                    end else if (fill_reg == FILL_W'(DEPTH)) begin
                        res_status_next = kfwrl_pkg::ST_TABLE_FULL;
                    end else begin
                        // Rows are never freed, so the lowest free row is the fill count.
                        ram_req.wr_en          = 1'b1;
                        ram_req.wr_addr        = fill_reg[IDX_W-1:0];
                        ram_req.wr_data.key    = key_reg;
                        ram_req.wr_data.expiry = expiry_reg;
                        ram_req.wr_data.limit  = limit_reg;
                        ram_req.wr_data.count  = '0;
                        cvalid_next[fill_reg[IDX_W-1:0]] = 1'b1;
                        fill_next       = fill_reg + FILL_W'(1);
                        res_status_next = kfwrl_pkg::ST_PROCESSED;
                    end
                end
            end

            S_UPDATE: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = hit_idx_reg;
                cvalid_next[hit_idx_reg] = 1'b1;
                if (op_reg == kfwrl_pkg::OP_REQUEST) begin
                    ram_req.wr_data       = ram_rd;
                    ram_req.wr_data.count = cnt_new;
                    res_count_next        = cnt_new;
                    res_status_next       = over ? kfwrl_pkg::ST_RATELIMIT : kfwrl_pkg::ST_OK;
                end else begin
                    ram_req.wr_data.key    = ram_rd.key;
                    ram_req.wr_data.expiry = expiry_reg;
                    ram_req.wr_data.limit  = limit_reg;
                    ram_req.wr_data.count  = cnt_eff;
                    res_status_next        = kfwrl_pkg::ST_PROCESSED;
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = res_status_reg;
                    m_data_next.use_count = res_count_reg;
                    state_next            = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            fill_reg    <= '0;
            cvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            fill_reg    <= fill_next;
            cvalid_reg  <= cvalid_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg         <= op_next;
        key_reg        <= key_next;
        now_reg        <= now_next;
        expiry_reg     <= expiry_next;
        limit_reg      <= limit_next;
        scan_reg       <= scan_next;
        pend_idx_reg   <= pend_idx_next;
        hit_idx_reg    <= hit_idx_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign seq_stat.busy = (state_reg != S_IDLE);
    assign seq_stat.fill = fill_reg;

endmodule

/* hw/rtl/keyed_fixed_window_rate_limiter_top.sv */
// ----------------------------------------------------------------------------
// keyed_fixed_window_rate_limiter_top
// Per-client fixed-window rate limiter over a bounded table of client keys.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Word
//   s_*       in         s_valid/s_ready    kfwrl_pkg::in_word_t
//   m_*       out        m_valid/m_ready    kfwrl_pkg::out_word_t
//   cfg_*     in         cfg_we only        index + 64-bit data
//
// A tick, an admin request or a word answered NOTREADY goes from acceptance
// straight to the done state, which loads the result register. A search reads
// one table row per cycle; a hit goes on to the update state. The sequencer is back
// in idle, ready for the next word, once the result is loaded. Reset clears the
// fill count and the count-valid bits at once, so there is no clearing pass; a
// tick clears the count-valid bits. A result not taken stalls the sequencer.
//
`include "keyed_fixed_window_rate_limiter_top_defines.svh"

module keyed_fixed_window_rate_limiter_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  kfwrl_pkg::in_word_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output kfwrl_pkg::out_word_t  m_data
);

    kfwrl_pkg::cfg_stat_t cfg_stat;
    kfwrl_pkg::ram_req_t  ram_req;
    kfwrl_pkg::row_t      ram_rd;
    kfwrl_pkg::seq_stat_t seq_stat;

    // Configuration registers; the admin match looks at the word on offer.
    kfwrl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .probe_key (s_data.client_key),
        .cfg_stat  (cfg_stat)
    );

    // Sequencer with the shared key comparator and the result register.
    kfwrl_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_stat (cfg_stat),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .ram_req  (ram_req),
        .ram_rd   (ram_rd),
        .seq_stat (seq_stat)
    );

    // Client table: key, expiry, limit and use count in one row.
    kfwrl_ram #(
        .WIDTH (kfwrl_pkg::ROW_W),
        .DEPTH (kfwrl_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd)
    );

    // Once a word is taken, the block works on it and takes no other.
    `KFWRL_ASSERT_NEXT(a_busy_after_accept, aresetn, s_valid && s_ready, seq_stat.busy, "sequencer idle right after taking a word")

    // A result appears only at the end of a busy period.
    `KFWRL_ASSERT_NOW(a_result_after_work, aresetn, $rose(m_valid), !$past(s_ready), "result appeared without a busy period")

    // TABLE_FULL is only reported when every row is in use.
    `KFWRL_ASSERT_NOW(a_full_only_when_full, aresetn, m_valid && (m_data.status == kfwrl_pkg::ST_TABLE_FULL), seq_stat.fill == kfwrl_pkg::FILL_W'(kfwrl_pkg::TABLE_DEPTH), "TABLE_FULL with free rows")

endmodule

/* tb/keyed_fixed_window_rate_limiter_top_tb.sv */
// ----------------------------------------------------------------------------
// Keyed fixed-window rate limiter: self-checking testbench
// Drives request, add-user, tick and unused-operation words through the
// valid/ready input channel and checks every result word against a
// cycle-free model of the client table, with random gaps on both sides.
// ----------------------------------------------------------------------------
module keyed_fixed_window_rate_limiter_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kfwrl_pkg::*;

    // Settling time after the last result before a register write, and the
    // drain time at the end.
    localparam int IDLE_SETTLE  = 8;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_EDGE = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic [63:0]       KEY_ONES  = {64{1'b1}};

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block.
    // ------------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_READY;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_word_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_word_t   m_data;

    keyed_fixed_window_rate_limiter_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Mirror of the block's state: the configuration registers and the
    // client table. Key, expiry and limit of a row are only looked at once
    // the row is valid.
    // ------------------------------------------------------------------------
    logic                ready_mirror;
    logic [63:0]         admin_a_mirror;
    logic [63:0]         admin_b_mirror;
    logic [1:0]          admin_count_mirror;

    logic [KEY_BITS-1:0] row_key    [TABLE_DEPTH];
    bit                  row_valid  [TABLE_DEPTH];
    logic [TIME_W-1:0]   row_expiry [TABLE_DEPTH];
    logic [LIM_W-1:0]    row_limit  [TABLE_DEPTH];
    logic [CNT_W-1:0]    use_cnt    [TABLE_DEPTH];

    // Words waiting to be sent, and verdicts waiting for their result word.
    in_word_t  pending_words[$];
    out_word_t expected_verdicts[$];

    // Keys that the stimulus has tried to add; requests mostly pick from
    // here so that they reach the counting logic instead of the miss path.
    logic [63:0] known_keys[$];
    int          pool_cap = 40;

    int  words_queued   = 0;
    int  words_accepted = 0;
    int  fail_count     = 0;
    bit  calm           = 1'b0;

    // Index of the valid row holding key, or TABLE_DEPTH when it is absent.
    function automatic int find_row(logic [KEY_BITS-1:0] key);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (row_valid[i] && row_key[i] == key) return i;
        end
        return TABLE_DEPTH;
    endfunction

    // Applies one accepted word to the mirror and returns the result word
    // that the block has to produce for it.
    function automatic out_word_t predict_verdict(in_word_t w);
        out_word_t           v;
        logic [KEY_BITS-1:0] key;
        int                  slot;
        int                  next_cnt;
        int                  cap;
        bit                  is_admin;

        v.status    = ST_OK;
        v.use_count = '0;
        key         = w.client_key[KEY_BITS-1:0];
        is_admin    = (admin_count_mirror >= 2'd1 && key == admin_a_mirror[KEY_BITS-1:0]) ||
                      (admin_count_mirror >= 2'd2 && key == admin_b_mirror[KEY_BITS-1:0]);

        if (w.operation == OP_TICK) begin
            // A tick clears the window whether or not the block is ready.
            foreach (use_cnt[i]) use_cnt[i] = '0;
        end else if (w.operation == OP_UNUSED || !ready_mirror) begin
            v.status = ST_NOTREADY;
        end else if (w.operation == OP_REQUEST) begin
            if (!is_admin) begin
                slot = find_row(key);
                if (slot == TABLE_DEPTH) begin
                    v.status = ST_RATELIMIT;
                end else begin
                    // The count saturates one above the limit, and falls to
                    // that value when the limit has been lowered.
                    cap      = int'(row_limit[slot]) + 1;
                    next_cnt = int'(use_cnt[slot]) + 1;
                    if (next_cnt > cap) next_cnt = cap;
                    use_cnt[slot] = CNT_W'(next_cnt);
                    v.use_count   = CNT_W'(next_cnt);
                    if (next_cnt > int'(row_limit[slot]) || w.now_seconds > row_expiry[slot])
                        v.status = ST_RATELIMIT;
                end
            end
        end else begin
            slot = find_row(key);
            if (slot != TABLE_DEPTH) begin
                // Extending a user keeps its count.
                row_expiry[slot] = w.expiry_time;
                row_limit[slot]  = w.rate_limit;
                v.status         = ST_PROCESSED;
            end else begin
                slot = 0;
                while (slot < TABLE_DEPTH && row_valid[slot]) slot++;
                if (slot < TABLE_DEPTH) begin
                    row_key[slot]    = key;
                    row_valid[slot]  = 1'b1;
                    row_expiry[slot] = w.expiry_time;
                    row_limit[slot]  = w.rate_limit;
                    use_cnt[slot]    = '0;
                    v.status         = ST_PROCESSED;
                end else begin
                    v.status = ST_TABLE_FULL;
                end
            end
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Random shaping. Pauses are mostly short with the odd long one; while
    // calm is set, neither side idles at all.
    // ------------------------------------------------------------------------
    function automatic int pick_pause();
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Limits are mostly tiny so that windows overflow often.
    function automatic logic [LIM_W-1:0] pick_limit();
        if ($urandom_range(0, 9) < 7) return LIM_W'($urandom_range(0, 6));
        return LIM_W'($urandom());
    endfunction

    // Expiry times are mostly far in the future, sometimes right at the
    // edge value that request times also aim at, sometimes anywhere.
    function automatic logic [TIME_W-1:0] pick_expiry();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return TIME_MAX - TIME_W'($urandom_range(0, 1000));
        if (roll < 70) return TIME_EDGE;
        if (roll < 85) return TIME_W'($urandom_range(0, 2000000));
        return TIME_W'({$urandom(), $urandom()});
    endfunction

    function automatic in_word_t random_word();
        in_word_t    w;
        int unsigned roll;

        w.operation   = OP_REQUEST;
        w.client_key  = {$urandom(), $urandom()};
        w.expiry_time = pick_expiry();
        w.rate_limit  = pick_limit();
        roll = $urandom_range(0, 99);
        if (roll < 60)      w.now_seconds = TIME_W'($urandom_range(0, 1000000));
        else if (roll < 75) w.now_seconds = TIME_W'({$urandom(), $urandom()});
        else if (roll < 90) w.now_seconds = TIME_EDGE - 1 + TIME_W'($urandom_range(0, 2));
        else                w.now_seconds = TIME_W'($urandom_range(1000000, 3000000));

        roll = $urandom_range(0, 99);
        if (roll < 56) begin
            // Requests: mostly known clients, a few admins, the rest strangers.
            roll = $urandom_range(0, 99);
            if (roll < 84 && known_keys.size() > 0)
                w.client_key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else if (roll < 92)
                w.client_key = $urandom_range(0, 1) ? admin_a_mirror : admin_b_mirror;
        end else if (roll < 82) begin
            w.operation = OP_ADD_USER;
            if (known_keys.size() > 0 &&
                (known_keys.size() >= pool_cap || $urandom_range(0, 1) == 0))
                w.client_key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else
                known_keys.insert(known_keys.size(), w.client_key);
        end else if (roll < 93) begin
            w.operation = OP_TICK;
        end else begin
            w.operation = OP_UNUSED;
        end
        return w;
    endfunction

    task automatic add_word(logic [1:0] op, logic [63:0] key, logic [TIME_W-1:0] now,
                            logic [TIME_W-1:0] expiry, logic [LIM_W-1:0] limit);
        in_word_t w;
        w.operation   = op;
        w.client_key  = key;
        w.now_seconds = now;
        w.expiry_time = expiry;
        w.rate_limit  = limit;
        pending_words.insert(pending_words.size(), w);
        words_queued++;
    endtask

    task automatic queue_random(int count);
        repeat (count) begin
            pending_words.insert(pending_words.size(), random_word());
            words_queued++;
        end
    endtask

    // Returns once every queued word is accepted and every result has come,
    // plus an IDLE_SETTLE wait so the block is surely back at rest.
    task automatic wait_idle();
        while (words_accepted != words_queued || expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    // Register writes happen only with the block idle, so the mirror can
    // take the new value at once.
    task automatic write_reg(logic [1:0] index, logic [63:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            CFG_READY:       ready_mirror       = value[0];
            CFG_ADMIN_KEY_A: admin_a_mirror     = value;
            CFG_ADMIN_KEY_B: admin_b_mirror     = value;
            CFG_ADMIN_COUNT: admin_count_mirror = value[1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Input driver. On acceptance the word is run through the mirror and its
    // verdict queued. The payload only changes once the word is taken, and
    // s_valid gets at most one assignment per edge.
    // ------------------------------------------------------------------------
    int gap_left = 0;
    bit word_taken;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            gap_left = 0;
        end else begin
            word_taken = s_valid && s_ready;
            if (word_taken) begin
                expected_verdicts.insert(expected_verdicts.size(), predict_verdict(s_data));
                words_accepted++;
                gap_left = pick_pause();
            end
            if (!s_valid || word_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_data  <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each result word is checked field by field against the
    // oldest verdict; m_ready drops for random stretches whether or not a
    // result is on offer, so stalls land on every phase of a search.
    // ------------------------------------------------------------------------
    int        stall_left = 0;
    out_word_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result word with no verdict waiting: status %0d, use_count %0d",
                           m_data.status, m_data.use_count);
                    fail_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, m_data.status);
                        fail_count++;
                    end
                    if (m_data.use_count !== want.use_count) begin
                        $error("use_count mismatch: expected %0d, got %0d",
                               want.use_count, m_data.use_count);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_pause();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [63:0] k1;
        logic [63:0] k3;
        logic [63:0] fresh_key;
        int          free_rows;

        k1 = 64'h0123_4567_89AB_CDEF;
        k3 = 64'h8000_0000_0000_0000;

        // The mirror starts from the reset state of the block.
        ready_mirror       = 1'b0;
        admin_a_mirror     = '0;
        admin_b_mirror     = '0;
        admin_count_mirror = '0;
        foreach (row_valid[i]) begin
            row_key[i]    = '0;
            row_valid[i]  = 1'b0;
            row_expiry[i] = '0;
            row_limit[i]  = '0;
            use_cnt[i]    = '0;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Straight out of reset the block is not ready: requests, adds and
        // the unused operation answer NOTREADY, while a tick still answers OK.
        add_word(OP_REQUEST, k1, '0, TIME_MAX, 16'd2);
        add_word(OP_ADD_USER, k1, '0, TIME_MAX, 16'd2);
        add_word(OP_TICK, '0, '0, '0, '0);
        add_word(OP_UNUSED, KEY_ONES, TIME_MAX, TIME_MAX, 16'hFFFF);
        wait_idle();

        write_reg(CFG_READY, 64'd1);
        write_reg(CFG_ADMIN_KEY_A, KEY_ONES);
        write_reg(CFG_ADMIN_KEY_B, 64'h5A5A_5A5A_C3C3_C3C3);
        write_reg(CFG_ADMIN_COUNT, 64'd1);

        // Window counting: two allowed uses, then rejection with the count
        // pinned one above the limit.
        add_word(OP_ADD_USER, k1, '0, TIME_MAX, 16'd2);
        add_word(OP_REQUEST, k1, '0, '0, '0);
        add_word(OP_REQUEST, k1, '0, '0, '0);
        add_word(OP_REQUEST, k1, '0, '0, '0);
        add_word(OP_REQUEST, k1, '0, '0, '0);
        // Lowering the limit of a known user drops its count to the new cap.
        add_word(OP_ADD_USER, k1, '0, TIME_MAX, 16'd1);
        add_word(OP_REQUEST, k1, '0, '0, '0);
        // A tick opens a new window; a request exactly at expiry still passes.
        add_word(OP_TICK, k1, TIME_MAX, TIME_MAX, 16'hFFFF);
        add_word(OP_REQUEST, k1, TIME_MAX, '0, '0);
        // A zero limit rejects the very first use.
        add_word(OP_ADD_USER, 64'd0, '0, 40'd100, 16'd0);
        add_word(OP_REQUEST, 64'd0, 40'd100, '0, '0);
        // Largest limit; expired one second late, fine at the expiry itself.
        add_word(OP_ADD_USER, k3, '0, 40'd1000, 16'hFFFF);
        add_word(OP_REQUEST, k3, 40'd1001, '0, '0);
        add_word(OP_REQUEST, k3, 40'd1000, '0, '0);
        // Strangers are refused and not inserted; only the first admin
        // register is in use, so the second one counts as a stranger.
        add_word(OP_REQUEST, 64'h1234, '0, '0, '0);
        add_word(OP_REQUEST, KEY_ONES, '0, '0, '0);
        add_word(OP_REQUEST, 64'h5A5A_5A5A_C3C3_C3C3, '0, '0, '0);
        // An admin key that is also a table user still bypasses counting.
        add_word(OP_ADD_USER, KEY_ONES, '0, TIME_MAX, 16'd3);
        add_word(OP_REQUEST, KEY_ONES, '0, '0, '0);
        add_word(OP_UNUSED, k1, '0, '0, '0);
        add_word(OP_REQUEST, k1, TIME_MAX, '0, '0);
        known_keys.insert(known_keys.size(), k1);
        known_keys.insert(known_keys.size(), 64'd0);
        known_keys.insert(known_keys.size(), k3);
        wait_idle();

        // Both admin registers in use, the second one at zero so that a
        // table user turns into an admin. Halfway through, the sender holds
        // back until every result has come.
        write_reg(CFG_ADMIN_KEY_B, 64'd0);
        write_reg(CFG_ADMIN_COUNT, 64'd2);
        queue_random(75);
        wait_idle();
        queue_random(75);
        wait_idle();

        // An admin count of three behaves as two. This stretch runs with
        // no idling on either side.
        write_reg(CFG_ADMIN_KEY_A, known_keys[$urandom_range(0, known_keys.size() - 1)]);
        write_reg(CFG_ADMIN_KEY_B, {$urandom(), $urandom()});
        write_reg(CFG_ADMIN_COUNT, 64'd3);
        calm = 1'b1;
        queue_random(150);
        wait_idle();
        calm = 1'b0;

        // Not ready again, no admins: only ticks get through.
        write_reg(CFG_READY, 64'd0);
        write_reg(CFG_ADMIN_COUNT, 64'd0);
        queue_random(60);
        wait_idle();

        // Fill the table to the last row and go past it, so the later adds
        // of new users answer TABLE_FULL.
        write_reg(CFG_READY, 64'd1);
        write_reg(CFG_ADMIN_COUNT, 64'd1);
        free_rows = 0;
        foreach (row_valid[i]) if (!row_valid[i]) free_rows++;
        repeat (free_rows + 8) begin
            fresh_key = {$urandom(), $urandom()};
            known_keys.insert(known_keys.size(), fresh_key);
            add_word(OP_ADD_USER, fresh_key, '0, pick_expiry(), pick_limit());
        end
        wait_idle();

        // Full table: extensions still work, new users are turned away.
        pool_cap = 90;
        write_reg(CFG_ADMIN_KEY_B, known_keys[$urandom_range(0, known_keys.size() - 1)]);
        write_reg(CFG_ADMIN_COUNT, 64'd2);
        queue_random(330);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_verdicts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/kfwrl_pkg.sv
hw/rtl/kfwrl_ram.sv
hw/rtl/kfwrl_cfg.sv
hw/rtl/kfwrl_seq.sv
hw/rtl/keyed_fixed_window_rate_limiter_top.sv
tb/keyed_fixed_window_rate_limiter_top_tb.sv
